// File: design/mean_and_stdev_engine_defines.svh
// Assertion macros shared by the mean and deviation engine modules.
`ifndef MEAN_AND_STDEV_ENGINE_DEFINES_SVH
`define MEAN_AND_STDEV_ENGINE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MSE_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MSE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mse_pkg.sv
// Shared types for the mean and deviation engine: controller states and datapath commands.
package mse_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_MUL_N,
    ST_MUL_M_LOAD,
    ST_MUL_M,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_DIV_MEAN_LOAD,
    ST_DIV_MEAN,
    ST_DIV_SD_LOAD,
    ST_DIV_SD,
    ST_FINISH
  } ctl_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCUM,
    OP_CLEAR,
    OP_MUL_N_LOAD,
    OP_MUL_STEP,
    OP_MUL_M_LOAD,
    OP_SQRT_LOAD,
    OP_SQRT_STEP,
    OP_DIV_MEAN_LOAD,
    OP_DIV_STEP,
    OP_DIV_SD_LOAD,
    OP_EMIT
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic out_busy;
  } dp_status_t;

endpackage

// File: design/mse_datapath.sv
// Datapath: accumulators, shift-add multiplier, digit-pair square root, restoring divider.
`include "mean_and_stdev_engine_defines.svh"

module mse_datapath #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mse_pkg::dp_cmd_t        cmd_i,
  output mse_pkg::dp_status_t     status_o,
  input  logic [SAMPLE_BITS-1:0]  sample_value_i,
  input  logic                    sample_valid_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [31:0]             mean_q16_o,
  output logic [31:0]             stdev_q16_o,
  output logic [15:0]             sample_count_o,
  output logic                    set_empty_o
);
  import mse_pkg::*;

  localparam int SumW  = SAMPLE_BITS + COUNT_BITS;
  localparam int MagW  = SAMPLE_BITS + COUNT_BITS - 1;
  localparam int SqW   = 2 * SAMPLE_BITS + COUNT_BITS - 2;
  localparam int ProdW = 2 * MagW;
  localparam int RootW = MagW + 16;
  localparam int RadW  = 2 * RootW;
  localparam int RemW  = RootW + 2;
  localparam int DvdW  = RootW;
  localparam int QxW   = (DvdW > 33) ? DvdW : 33;
  localparam int CxW   = (COUNT_BITS > 16) ? COUNT_BITS : 16;

  // accumulators
  logic signed [SumW-1:0]       sum_q;
  logic [SqW-1:0]               sumsq_q;
  logic [COUNT_BITS-1:0]        count_q;
  logic signed [SAMPLE_BITS-1:0] sample_s;
  logic signed [2*SAMPLE_BITS-1:0] sample_sq;

  // iterative units
  logic                         neg_q;
  logic [MagW-1:0]              mag_q;
  logic [ProdW-1:0]             mcand_q;
  logic [MagW-1:0]              mplier_q;
  logic [ProdW-1:0]             prod_q;
  logic [ProdW-1:0]             nsq_q;
  logic [RadW-1:0]              rad_q;
  logic [RemW-1:0]              rem_q;
  logic [RootW-1:0]             root_q;
  logic [DvdW-1:0]              dvd_q;
  logic [COUNT_BITS:0]          drem_q;
  logic [31:0]                  mean_q;

  // output register
  logic                         out_valid_q;
  logic [31:0]                  out_mean_q;
  logic [31:0]                  out_stdev_q;
  logic [15:0]                  out_count_q;
  logic                         out_empty_q;

  logic signed [SumW-1:0]       sum_neg;
  logic [MagW-1:0]              mag_d;
  logic [ProdW-1:0]             var_d;
  logic [RemW-1:0]              rem_t;
  logic [RemW-1:0]              trial;
  logic                         rt_ge;
  logic [COUNT_BITS:0]          drem_t;
  logic                         div_ge;
  logic [QxW-1:0]               quo_x;
  logic [31:0]                  quo_m;
  logic [31:0]                  mean_sat;
  logic [31:0]                  stdev_sat;
  logic [CxW-1:0]               count_x;
  logic [15:0]                  count_sat;
  logic                         acc_en;

  assign sample_s  = sample_value_i;
  assign sample_sq = sample_s * sample_s;
  assign acc_en    = sample_valid_i && (count_q != '1);

  assign sum_neg = -sum_q;
  assign mag_d   = sum_q[SumW-1] ? sum_neg[MagW-1:0] : sum_q[MagW-1:0];
  assign var_d   = (nsq_q >= prod_q) ? (nsq_q - prod_q) : '0;

  assign rem_t = {rem_q[RemW-3:0], rad_q[RadW-1 -: 2]};
  assign trial = {root_q, 2'b01};
  assign rt_ge = rem_t >= trial;

  assign drem_t = {drem_q[COUNT_BITS-1:0], dvd_q[DvdW-1]};
  assign div_ge = drem_t >= {1'b0, count_q};

  // saturate quotients into the 32-bit result formats
  always_comb begin
    quo_x = QxW'(dvd_q);
    if (neg_q) begin
      quo_m    = (quo_x > QxW'(33'h0_8000_0000)) ? 32'h8000_0000 : quo_x[31:0];
      mean_sat = 32'd0 - quo_m;
    end else begin
      quo_m    = (quo_x > QxW'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : quo_x[31:0];
      mean_sat = quo_m;
    end
    stdev_sat = (quo_x > QxW'(33'h0_FFFF_FFFF)) ? 32'hFFFF_FFFF : quo_x[31:0];
    count_x   = CxW'(count_q);
    count_sat = (count_x > CxW'(17'h0_FFFF)) ? 16'hFFFF : count_x[15:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      sumsq_q     <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && (cmd_i.op != OP_EMIT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_ACCUM: begin
          if (acc_en) begin
            sum_q   <= sum_q + SumW'(sample_s);
            sumsq_q <= sumsq_q + SqW'($unsigned(sample_sq));
            count_q <= count_q + 1'b1;
          end
        end
        OP_CLEAR: begin
          sum_q   <= '0;
          sumsq_q <= '0;
          count_q <= '0;
        end
        OP_EMIT: begin
          sum_q       <= '0;
          sumsq_q     <= '0;
          count_q     <= '0;
          out_valid_q <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_MUL_N_LOAD: begin
        neg_q    <= sum_q[SumW-1];
        mag_q    <= mag_d;
        mcand_q  <= ProdW'(sumsq_q);
        mplier_q <= MagW'(count_q);
        prod_q   <= '0;
      end
      OP_MUL_STEP: begin
        if (mplier_q[0]) begin
          prod_q <= prod_q + mcand_q;
        end
        mcand_q  <= {mcand_q[ProdW-2:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[MagW-1:1]};
      end
      OP_MUL_M_LOAD: begin
        nsq_q    <= prod_q;
        mcand_q  <= ProdW'(mag_q);
        mplier_q <= mag_q;
        prod_q   <= '0;
      end
      OP_SQRT_LOAD: begin
        rad_q  <= {var_d, 32'd0};
        rem_q  <= '0;
        root_q <= '0;
      end
      OP_SQRT_STEP: begin
        rad_q <= {rad_q[RadW-3:0], 2'b00};
        if (rt_ge) begin
          rem_q  <= rem_t - trial;
          root_q <= {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_q  <= rem_t;
          root_q <= {root_q[RootW-2:0], 1'b0};
        end
      end
      OP_DIV_MEAN_LOAD: begin
        dvd_q  <= {mag_q, 16'd0};
        drem_q <= '0;
      end
      OP_DIV_STEP: begin
        drem_q <= div_ge ? (drem_t - {1'b0, count_q}) : drem_t;
        dvd_q  <= {dvd_q[DvdW-2:0], div_ge};
      end
      OP_DIV_SD_LOAD: begin
        mean_q <= mean_sat;
        dvd_q  <= root_q;
        drem_q <= '0;
      end
      OP_EMIT: begin
        // an empty set skips the arithmetic, so force its fields to zero
        out_empty_q <= (count_q == '0);
        out_mean_q  <= (count_q == '0) ? 32'd0 : mean_q;
        out_stdev_q <= (count_q == '0) ? 32'd0 : stdev_sat;
        out_count_q <= count_sat;
      end
      default: begin
      end
    endcase
  end

  assign status_o.count_zero = (count_q == '0);
  assign status_o.out_busy   = out_valid_q && out_stall_i;

  assign out_valid_o    = out_valid_q;
  assign mean_q16_o     = out_mean_q;
  assign stdev_q16_o    = out_stdev_q;
  assign sample_count_o = out_count_q;
  assign set_empty_o    = out_empty_q;

  `MSE_ASSERT_NEXT(a_emit_clears, cmd_i.op == OP_EMIT, (count_q == '0) && (sum_q == '0) && out_valid_q, "emit did not clear the set")
  `MSE_ASSERT_SAME(a_empty_zero, out_valid_q && out_empty_q, (out_mean_q == 32'd0) && (out_stdev_q == 32'd0) && (out_count_q == 16'd0), "empty result carries nonzero fields")

endmodule

// File: design/mse_ctrl.sv
// Controller: item handshake, enable register and the sequence of the end-of-set computation.
`include "mean_and_stdev_engine_defines.svh"

module mse_ctrl #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 set_last_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic                 cfg_data_i,
  output mse_pkg::dp_cmd_t     cmd_o,
  input  mse_pkg::dp_status_t  status_i
);
  import mse_pkg::*;

  localparam int MagW = SAMPLE_BITS + COUNT_BITS - 1;
  localparam int DvdW = MagW + 16;
  localparam int CntW = $clog2(DvdW);

  ctl_state_e      state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            en_q;
  logic            accept;
  logic            cnt_done;

  assign accept   = in_valid_i && !in_stall_o;
  assign cnt_done = (cnt_q == '0);

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      en_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and iteration count
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_done ? cnt_q : cnt_q - 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && set_last_i && en_q) begin
          state_d = ST_START;
        end
      end
      ST_START: begin
        if (status_i.count_zero) begin
          state_d = ST_FINISH;
        end else begin
          state_d = ST_MUL_N;
          cnt_d   = CntW'(COUNT_BITS - 1);
        end
      end
      ST_MUL_N: begin
        if (cnt_done) begin
          state_d = ST_MUL_M_LOAD;
        end
      end
      ST_MUL_M_LOAD: begin
        state_d = ST_MUL_M;
        cnt_d   = CntW'(MagW - 1);
      end
      ST_MUL_M: begin
        if (cnt_done) begin
          state_d = ST_SQRT_LOAD;
        end
      end
      ST_SQRT_LOAD: begin
        state_d = ST_SQRT;
        cnt_d   = CntW'(DvdW - 1);
      end
      ST_SQRT: begin
        if (cnt_done) begin
          state_d = ST_DIV_MEAN_LOAD;
        end
      end
      ST_DIV_MEAN_LOAD: begin
        state_d = ST_DIV_MEAN;
        cnt_d   = CntW'(DvdW - 1);
      end
      ST_DIV_MEAN: begin
        if (cnt_done) begin
          state_d = ST_DIV_SD_LOAD;
        end
      end
      ST_DIV_SD_LOAD: begin
        state_d = ST_DIV_SD;
        cnt_d   = CntW'(DvdW - 1);
      end
      ST_DIV_SD: begin
        if (cnt_done) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // commands and handshake
  always_comb begin
    in_stall_o = 1'b1;
    cmd_o.op   = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          // drop the set outright when results are off
          cmd_o.op = (set_last_i && !en_q) ? OP_CLEAR : OP_ACCUM;
        end
      end
      ST_START:         cmd_o.op = OP_MUL_N_LOAD;
      ST_MUL_N:         cmd_o.op = OP_MUL_STEP;
      ST_MUL_M_LOAD:    cmd_o.op = OP_MUL_M_LOAD;
      ST_MUL_M:         cmd_o.op = OP_MUL_STEP;
      ST_SQRT_LOAD:     cmd_o.op = OP_SQRT_LOAD;
      ST_SQRT:          cmd_o.op = OP_SQRT_STEP;
      ST_DIV_MEAN_LOAD: cmd_o.op = OP_DIV_MEAN_LOAD;
      ST_DIV_MEAN:      cmd_o.op = OP_DIV_STEP;
      ST_DIV_SD_LOAD:   cmd_o.op = OP_DIV_SD_LOAD;
      ST_DIV_SD:        cmd_o.op = OP_DIV_STEP;
      ST_FINISH: begin
        if (!status_i.out_busy) begin
          cmd_o.op = OP_EMIT;
        end
      end
      default: begin
        cmd_o.op = OP_NONE;
      end
    endcase
  end

  `MSE_ASSERT_SAME(a_emit_free, cmd_o.op == OP_EMIT, !status_i.out_busy, "emit while output register is held")
  `MSE_ASSERT_NEXT(a_last_starts, accept && set_last_i && en_q, state_q == ST_START, "last item did not start the computation")
  `MSE_ASSERT_NEXT(a_empty_skips, (state_q == ST_START) && status_i.count_zero, state_q == ST_FINISH, "empty set did not skip the arithmetic")

endmodule

// File: design/mean_and_stdev_engine.sv
// Top level of the population mean and standard deviation engine.
//
// Usage: samples enter on the input channel (in_valid_i / in_stall_o), one item per
// cycle while the engine is collecting; sample_valid_i = 0 makes an item a bare marker
// and set_last_i closes the data set. Results leave on the output channel
// (out_valid_o / out_stall_i), one item per finished set, with mean and deviation in
// Q.16. stats_enable is written through cfg_valid_i / cfg_ready_o / cfg_data_i.
// An item without set_last is accepted without stalling the input. A set_last item stalls
// the input while the shift-add multiplier, square-root unit and restoring divider
// iterate one bit or one bit pair per cycle; an empty set skips that arithmetic. The
// result sits in an output register: collection of the next set proceeds while the
// receiver stalls, and only a later set_last waits for that register to drain.
// Reset clears the running count, sum and sum of squares, empties the output register
// and sets stats_enable to 1.
module mean_and_stdev_engine #(
  parameter int SAMPLE_BITS = 16,
  parameter int COUNT_BITS  = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SAMPLE_BITS-1:0] sample_value_i,
  input  logic                   sample_valid_i,
  input  logic                   set_last_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [31:0]            mean_q16_o,
  output logic [31:0]            stdev_q16_o,
  output logic [15:0]            sample_count_o,
  output logic                   set_empty_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_data_i
);
  import mse_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  mse_ctrl #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .set_last_i  (set_last_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  mse_datapath #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .sample_value_i (sample_value_i),
    .sample_valid_i (sample_valid_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .mean_q16_o     (mean_q16_o),
    .stdev_q16_o    (stdev_q16_o),
    .sample_count_o (sample_count_o),
    .set_empty_o    (set_empty_o)
  );

endmodule
